// ----- rtl/core/pfba_pkg.sv -----
`default_nettype none

package pfba_pkg;

    // Map geometry
    localparam int NUM_FRAMES_DEF = 1024;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;
    // Frame arithmetic width, holds any 11-bit register value and NUM_FRAMES up to 4096
    localparam int CALC_W         = 14;

    // Payload widths
    localparam int CMD_W          = 2;
    localparam int FRAME_IN_W     = 16;
    localparam int FRAME_OUT_W    = 10;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;

    // Fixed reserved frames marked at init
    localparam logic [CALC_W-1:0] GDT_FRAME = CALC_W'(14'h090);
    localparam logic [CALC_W-1:0] DEV_FIRST = CALC_W'(14'h0A0);
    localparam logic [CALC_W-1:0] DEV_END   = CALC_W'(14'h100);

    // Configuration registers
    localparam logic [CFG_IDX_W-1:0] CFG_KFIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEND   = 1'b1;
    localparam logic [CFG_W-1:0]     KFIRST_RST = 11'd16;
    localparam logic [CFG_W-1:0]     KEND_RST   = 11'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NONE_FREE    = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC_RD,
        S_ALLOC_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_enc;

    // Bits of the word at base (word aligned) whose frame lies in [lo, hi)
    function automatic logic [WORD_W-1:0] range_mask(
        input logic [CALC_W-1:0] base,
        input logic [CALC_W-1:0] lo,
        input logic [CALC_W-1:0] hi
    );
        logic [WORD_W-1:0] m;
        logic [CALC_W-1:0] f;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            f    = {base[CALC_W-1:BIT_W], b[BIT_W-1:0]};
            m[b] = (f >= lo) && (f < hi);
        end
        return m;
    endfunction

    // Lowest set bit of a word
    function automatic t_enc first_one(input logic [WORD_W-1:0] v);
        t_enc e;
        e.found = 1'b0;
        e.idx   = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                e.found = 1'b1;
                e.idx   = b[BIT_W-1:0];
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/physical_frame_bitmap_allocator.sv -----
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_cmd, i_frame_in
// out       output     o_out_valid / i_out_ready   o_frame_out, o_status
// cfg       input      i_cfg_wr_en                 i_cfg_idx, i_cfg_wdata
//
// The map is held as NUM_FRAMES/32 words of 32 marks in one memory; a single
// priority encoder checks one word per cycle. Alloc reads the start word, then
// scans from it up to the last word; init writes one word per cycle; an
// in-range free reads its word, then clears its bit; other commands, frees out
// of range and allocs with the scan start beyond the map go straight to done.
// Reset is synchronous; per-word valid flops make the map read as all free.
// The input is taken only when idle; a finished result waits in the output
// register, the next command is taken meanwhile and stalls only at its end.
// NUM_FRAMES must be a multiple of 32.

module physical_frame_bitmap_allocator #(
    parameter int NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command transaction
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [pfba_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [pfba_pkg::FRAME_IN_W-1:0]  i_frame_in,
    // result transaction
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [pfba_pkg::FRAME_OUT_W-1:0]      o_frame_out,
    output pfba_pkg::t_status                     o_status,
    // configuration writes
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pfba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pfba_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import pfba_pkg::*;

    localparam int WORDS  = NUM_FRAMES / WORD_W;
    localparam int WIDX_W = $clog2(WORDS);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);

    // State and registers
    t_state                 r_state, n_state;
    logic [WIDX_W-1:0]      r_widx, n_widx;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [FRAME_OUT_W-1:0] r_res_frame, n_res_frame;
    t_status                r_res_status, n_res_status;
    logic                   r_out_valid;
    logic [FRAME_OUT_W-1:0] r_out_frame;
    t_status                r_out_status;
    logic [CFG_W-1:0]       r_kfirst, r_kend;

    // Map memory and per-word valid flops
    logic [WORD_W-1:0]      mem [WORDS];
    logic [WORDS-1:0]       r_word_vld;
    logic [WORD_W-1:0]      r_mem_q;
    logic                   r_vld_q;

    // Memory port controls
    logic                   mem_we;
    logic [WIDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;
    logic [WIDX_W-1:0]      mem_raddr;

    // Datapath helpers
    logic                   in_acc;
    logic                   out_load;
    logic [WORD_W-1:0]      rd_word;
    logic [CALC_W-1:0]      kend_ext;
    logic [CALC_W-1:0]      kfirst_ext;
    logic                   kend_ge;
    logic [WIDX_W-1:0]      start_widx;
    logic [WORD_W-1:0]      scan_mask;
    t_enc                   enc;
    logic [CALC_W-1:0]      found_frame;
    logic [CALC_W-1:0]      word_base;
    logic                   free_in_range;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_frame_out = r_out_frame;
    assign o_status    = r_out_status;

    assign rd_word       = r_vld_q ? r_mem_q : '0;
    assign kend_ext      = CALC_W'(r_kend);
    assign kfirst_ext    = CALC_W'(r_kfirst);
    assign kend_ge       = (kend_ext >= CALC_W'(NUM_FRAMES));
    assign start_widx    = kend_ext[WIDX_W+BIT_W-1:BIT_W];
    assign scan_mask     = (r_widx == start_widx) ? ({WORD_W{1'b1}} << r_kend[BIT_W-1:0])
                                                  : {WORD_W{1'b1}};
    assign enc           = first_one(~rd_word & scan_mask);
    assign found_frame   = CALC_W'({r_widx, enc.idx});
    assign word_base     = CALC_W'({r_widx, {BIT_W{1'b0}}});
    assign free_in_range = (i_frame_in < FRAME_IN_W'(NUM_FRAMES));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_cmd))
                        CMD_ALLOC: n_state = kend_ge ? S_DONE : S_ALLOC_RD;
                        CMD_FREE:  n_state = free_in_range ? S_FREE_RD : S_DONE;
                        CMD_INIT:  n_state = S_INIT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                if (r_widx == LAST_WORD) n_state = S_DONE;
            end
            S_ALLOC_RD: n_state = S_ALLOC_SCAN;
            S_ALLOC_SCAN: begin
                if (enc.found || (r_widx == LAST_WORD)) n_state = S_DONE;
            end
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls per state
    always_comb begin
        n_widx       = r_widx;
        n_bit        = r_bit;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_waddr    = r_widx;
        mem_wdata    = '0;
        mem_raddr    = r_widx;
        case (r_state)
            S_IDLE: begin
                n_res_frame  = '0;
                n_res_status = ST_OK;
                case (t_cmd'(i_cmd))
                    CMD_ALLOC: begin
                        n_widx = start_widx;
                        if (kend_ge) n_res_status = ST_NONE_FREE;
                    end
                    CMD_FREE: begin
                        n_widx = i_frame_in[WIDX_W+BIT_W-1:BIT_W];
                        n_bit  = i_frame_in[BIT_W-1:0];
                        if (!free_in_range) n_res_status = ST_OUT_OF_RANGE;
                    end
                    CMD_INIT: n_widx = '0;
                    default:  n_widx = r_widx;
                endcase
            end
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = range_mask(word_base, kfirst_ext, kend_ext)
                          | range_mask(word_base, GDT_FRAME, GDT_FRAME + CALC_W'(1))
                          | range_mask(word_base, DEV_FIRST, DEV_END);
                n_widx    = WIDX_W'(r_widx + WIDX_W'(1));
            end
            S_ALLOC_RD: mem_raddr = r_widx;
            S_ALLOC_SCAN: begin
                // read of the next word overlaps the check of this one
                mem_raddr = WIDX_W'(r_widx + WIDX_W'(1));
                if (enc.found) begin
                    mem_we      = 1'b1;
                    mem_wdata   = rd_word | (WORD_W'(1) << enc.idx);
                    n_res_frame = found_frame[FRAME_OUT_W-1:0];
                end else if (r_widx == LAST_WORD) begin
                    n_res_status = ST_NONE_FREE;
                end else begin
                    n_widx = WIDX_W'(r_widx + WIDX_W'(1));
                end
            end
            S_FREE_RD: mem_raddr = r_widx;
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rd_word & ~(WORD_W'(1) << r_bit);
            end
            S_DONE: mem_raddr = r_widx;
            default: mem_raddr = r_widx;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kfirst    <= KFIRST_RST;
            r_kend      <= KEND_RST;
            r_word_vld  <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_KFIRST) r_kfirst <= i_cfg_wdata;
                if (i_cfg_idx == CFG_KEND)   r_kend   <= i_cfg_wdata;
            end
            if (mem_we) r_word_vld[mem_waddr] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_widx       <= n_widx;
        r_bit        <= n_bit;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_frame  <= r_res_frame;
            r_out_status <= r_res_status;
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_mem_q <= mem[mem_raddr];
        r_vld_q <= r_word_vld[mem_raddr];
    end

    // Alloc with the scan start beyond the map answers at once
    a_alloc_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_ALLOC) && kend_ge)
        |=> (r_state == S_DONE) && (r_res_status == ST_NONE_FREE))
        else $error("alloc beyond map did not finish with none free");

    // The scan never looks below the start word
    a_scan_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_SCAN) |-> (r_widx >= start_widx))
        else $error("alloc scan below kernel end");

    // A result enters the output register only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output loaded outside done state");

    // The map is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE) && (r_state != S_DONE))
        else $error("map written while idle");

endmodule

`default_nettype wire
